FILE: rtl/bss_pkg.sv
// Package for the binned SAH split search: widths, word types, state codes
// and the bin merge function. No dependencies.
package bss_pkg;

  localparam int BINS       = 64;
  localparam int BIN_W      = $clog2(BINS);
  localparam int COORD_BITS = 20;
  localparam int EXT_W      = COORD_BITS + 1;
  localparam int MAX_PRIMS  = 65535;
  localparam int CNT_W      = 16;
  localparam int AREA_W     = 44;
  localparam int COST_W     = 61;
  localparam int AX_N       = 3;
  localparam int ADDR_W     = $clog2(AX_N * BINS);
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int DCNT_W     = $clog2(BIN_W + 1);

  localparam logic CMD_NODE = 1'b0;
  localparam logic CMD_PRIM = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    coord_t [2:0]     lo;
    coord_t [2:0]     hi;
  } bin_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [AREA_W-1:0] area;
  } side_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_BRD, S_BWR, S_ITEM_END, S_SAX, S_SRD, S_SMRG,
    S_SMUL, S_SWR, S_CRD, S_CMUL, S_CCMP, S_FIN
  } state_t;

  function automatic bin_t bin_empty();
    bin_t r;
    r.cnt = '0;
    for (int c = 0; c < 3; c++) begin
      r.lo[c] = CMAX;
      r.hi[c] = CMIN;
    end
    return r;
  endfunction

  function automatic bin_t bin_merge(bin_t a, bin_t b);
    bin_t r;
    logic [CNT_W:0] s;
    s = {1'b0, a.cnt} + {1'b0, b.cnt};
    r.cnt = (s > (CNT_W+1)'(MAX_PRIMS)) ? CNT_W'(MAX_PRIMS) : s[CNT_W-1:0];
    for (int c = 0; c < 3; c++) begin
      r.lo[c] = ($signed(b.lo[c]) < $signed(a.lo[c])) ? b.lo[c] : a.lo[c];
      r.hi[c] = ($signed(b.hi[c]) > $signed(a.hi[c])) ? b.hi[c] : a.hi[c];
    end
    return r;
  endfunction

endpackage

FILE: rtl/bss_in_if.sv
// Input channel of the split search: valid/ready and one item word.
// Depends on bss_pkg.
interface bss_in_if import bss_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  coord_t cent_x;
  coord_t cent_y;
  coord_t cent_z;
  coord_t box_lo_x;
  coord_t box_lo_y;
  coord_t box_lo_z;
  coord_t box_hi_x;
  coord_t box_hi_y;
  coord_t box_hi_z;
  logic   last_item;

  modport source(output valid, cmd, cent_x, cent_y, cent_z, box_lo_x, box_lo_y, box_lo_z,
                 box_hi_x, box_hi_y, box_hi_z, last_item, input ready);
  modport sink(input valid, cmd, cent_x, cent_y, cent_z, box_lo_x, box_lo_y, box_lo_z,
               box_hi_x, box_hi_y, box_hi_z, last_item, output ready);
endinterface

FILE: rtl/bss_out_if.sv
// Result channel of the split search: valid/ready and one result word.
// Depends on bss_pkg.
interface bss_out_if import bss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [1:0]        best_axis;
  coord_t            split_pos;
  logic [COST_W-1:0] best_cost;

  modport source(output valid, found, best_axis, split_pos, best_cost, input ready);
  modport sink(input valid, found, best_axis, split_pos, best_cost, output ready);
endinterface

FILE: rtl/binned_sah_split_search_top.sv
// Binned SAH split search for one BVH node.
// A primitive word holds the input through the bin index division, then a read and
// a write of the bin memory per usable axis. A last word adds a sweep per usable axis
// and a final state, paced by the single-port bin memory and the side memories.
// Reset (synchronous, rst high) clears the node box and all bin valid bits.
module binned_sah_split_search_top import bss_pkg::*; (
  input logic       clk,
  input logic       rst,
  bss_in_if.sink    item,
  bss_out_if.source result
);

  state_t state, state_next;

  coord_t                  node_lo [3];
  coord_t                  node_hi [3];
  logic signed [EXT_W-1:0] ext [3];
  logic [2:0]              usable;

  bin_t itm;
  logic last_r;

  logic                    acc_in;
  logic                    div_start;
  logic signed [EXT_W-1:0] div_d [3];
  logic [2:0]              busy;
  logic [BIN_W-1:0]        q [3];

  logic [1:0]       ax;
  logic [BIN_W-1:0] idx;
  logic             sfx;
  logic [BIN_W-1:0] sw_bin;

  bin_t              bin_mem [AX_N*BINS];
  logic [AX_N*BINS-1:0] bin_vld;
  logic [ADDR_W-1:0] bin_addr;
  logic              bin_we;
  bin_t              bin_rd;
  logic              vld_rd;
  bin_t              bin_eff;

  bin_t              acc;
  logic [PROD_W-1:0] prod [3];
  logic              empty;
  logic [AREA_W-1:0] area;

  side_t             pmem [BINS-1];
  side_t             smem [BINS-1];
  side_t             prd, srd;
  logic              side_we;
  logic [COST_W-1:0] lc, rc, cost;

  logic [COST_W-1:0] best;
  logic              found;
  logic [1:0]        bax;
  logic [BIN_W-1:0]  bidx;
  logic [EXT_W+BIN_W:0] sp;
  coord_t            split;
  logic              out_free;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext[a]    = EXT_W'(node_hi[a]) - EXT_W'(node_lo[a]);
      usable[a] = ext[a] > 0;
    end
    div_d[0] = EXT_W'(item.cent_x) - EXT_W'(node_lo[0]);
    div_d[1] = EXT_W'(item.cent_y) - EXT_W'(node_lo[1]);
    div_d[2] = EXT_W'(item.cent_z) - EXT_W'(node_lo[2]);
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    bss_bin_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .d     (div_d[a]),
      .ext   (ext[a]),
      .busy  (busy[a]),
      .bin   (q[a])
    );
  end

  assign out_free = !result.valid || result.ready;
  assign bin_eff  = vld_rd ? bin_rd : bin_empty();
  assign sw_bin   = sfx ? BIN_W'(BINS - 1 - int'(idx)) : idx;
  assign cost     = lc + rc;
  assign area     = empty ? '0 : {(AREA_W-1)'(prod[0]) + (AREA_W-1)'(prod[1])
                                  + (AREA_W-1)'(prod[2]), 1'b0};
  assign sp       = {1'b0, ext[bax][EXT_W-1:0]} * ({1'b0, bidx} + 1'b1);
  assign split    = COORD_BITS'(node_lo[bax] + coord_t'(sp >> BIN_W));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (acc_in) begin
                    if (item.cmd == CMD_PRIM) state_next = S_DIV;
                    else if (item.last_item)  state_next = S_SAX;
                  end
      S_DIV:      if (!(|busy)) state_next = S_BRD;
      S_BRD:      if (ax == 2'd3) state_next = S_ITEM_END;
                  else if (usable[ax]) state_next = S_BWR;
      S_BWR:      state_next = S_BRD;
      S_ITEM_END: state_next = last_r ? S_SAX : S_IDLE;
      S_SAX:      if (ax == 2'd3) state_next = S_FIN;
                  else if (usable[ax]) state_next = S_SRD;
      S_SRD:      state_next = S_SMRG;
      S_SMRG:     state_next = S_SMUL;
      S_SMUL:     state_next = S_SWR;
      S_SWR:      if (idx == BIN_W'(BINS - 2) && sfx) state_next = S_CRD;
                  else state_next = S_SRD;
      S_CRD:      state_next = S_CMUL;
      S_CMUL:     state_next = S_CCMP;
      S_CCMP:     state_next = (idx == BIN_W'(BINS - 2)) ? S_SAX : S_CRD;
      S_FIN:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = (state == S_IDLE);
    acc_in     = item.valid && item.ready;
    div_start  = acc_in && (item.cmd == CMD_PRIM);
    bin_we     = (state == S_BWR);
    side_we    = (state == S_SWR);
    if (state == S_BRD || state == S_BWR) begin
      bin_addr = ADDR_W'(int'(ax) * BINS + int'(q[ax]));
    end else begin
      bin_addr = ADDR_W'(int'(ax) * BINS + int'(sw_bin));
    end
  end

  always_ff @(posedge clk) begin
    bin_rd <= bin_mem[bin_addr];
    vld_rd <= bin_vld[bin_addr];
    if (bin_we) begin
      bin_mem[bin_addr] <= bin_merge(bin_eff, itm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc_in && item.cmd == CMD_NODE)) begin
      bin_vld <= '0;
    end else if (bin_we) begin
      bin_vld[bin_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prd <= pmem[idx[BIN_W-1:0]];
    srd <= smem[idx[BIN_W-1:0]];
    if (side_we) begin
      if (sfx) smem[BIN_W'(BINS - 2 - int'(idx))] <= '{cnt: acc.cnt, area: area};
      else     pmem[idx] <= '{cnt: acc.cnt, area: area};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result.valid  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        node_lo[a] <= '0;
        node_hi[a] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc_in) begin
          ax        <= '0;
          last_r    <= item.last_item;
          itm.cnt   <= CNT_W'(1);
          itm.lo    <= {item.box_lo_z, item.box_lo_y, item.box_lo_x};
          itm.hi    <= {item.box_hi_z, item.box_hi_y, item.box_hi_x};
          best      <= COST_MAX;
          found     <= 1'b0;
          bax       <= '0;
          bidx      <= '0;
          if (item.cmd == CMD_NODE) begin
            node_lo[0] <= item.box_lo_x;
            node_lo[1] <= item.box_lo_y;
            node_lo[2] <= item.box_lo_z;
            node_hi[0] <= item.box_hi_x;
            node_hi[1] <= item.box_hi_y;
            node_hi[2] <= item.box_hi_z;
          end
        end
        S_DIV: ;
        S_BRD: if (ax != 2'd3 && !usable[ax]) ax <= ax + 1'b1;
        S_BWR: ax <= ax + 1'b1;
        S_ITEM_END: ax <= '0;
        S_SAX: begin
          idx <= '0;
          sfx <= 1'b0;
          acc <= bin_empty();
          if (ax != 2'd3 && !usable[ax]) ax <= ax + 1'b1;
        end
        S_SRD: ;
        S_SMRG: acc <= bin_merge(acc, bin_eff);
        S_SMUL: begin
          logic signed [EXT_W-1:0] dd [3];
          for (int c = 0; c < 3; c++) begin
            dd[c] = EXT_W'(acc.hi[c]) - EXT_W'(acc.lo[c]);
          end
          empty   <= dd[0] < 0 || dd[1] < 0 || dd[2] < 0;
          prod[0] <= dd[0][COORD_BITS-1:0] * dd[1][COORD_BITS-1:0];
          prod[1] <= dd[1][COORD_BITS-1:0] * dd[2][COORD_BITS-1:0];
          prod[2] <= dd[2][COORD_BITS-1:0] * dd[0][COORD_BITS-1:0];
        end
        S_SWR: begin
          if (idx == BIN_W'(BINS - 2)) begin
            idx <= '0;
            sfx <= 1'b1;
            acc <= bin_empty();
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CRD: ;
        S_CMUL: begin
          lc <= COST_W'(prd.cnt) * COST_W'(prd.area);
          rc <= COST_W'(srd.cnt) * COST_W'(srd.area);
        end
        S_CCMP: begin
          if (cost < best) begin
            best  <= cost;
            found <= 1'b1;
            bax   <= ax;
            bidx  <= idx;
          end
          if (idx == BIN_W'(BINS - 2)) ax <= ax + 1'b1;
          else idx <= idx + 1'b1;
        end
        S_FIN: if (out_free) begin
          result.found     <= found;
          result.best_axis <= found ? bax : 2'd0;
          result.split_pos <= found ? split : '0;
          result.best_cost <= best;
        end
        default: ;
      endcase
    end
  end

  a_nofound_cost: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.best_cost == COST_MAX)
    else $error("result without a split carries a finite cost");

  a_write_usable: assert property (@(posedge clk) disable iff (rst)
    state == S_BWR |-> usable[ax] && !(|busy))
    else $error("bin write on an unusable axis or before the index is ready");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_FIN)
    else $error("result word raised outside the final state");

endmodule

FILE: rtl/bss_bin_div.sv
// Bin index unit: floor(d*BINS/ext), clamped to 0 below and the last bin
// above, one quotient bit a cycle by restoring division. Uses bss_pkg.
module bss_bin_div import bss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [EXT_W-1:0] d,
  input  logic signed [EXT_W-1:0] ext,
  output logic                    busy,
  output logic [BIN_W-1:0]        bin
);

  logic [EXT_W-1:0]  rem;
  logic [EXT_W:0]    rem2;
  logic [EXT_W:0]    ext_u;
  logic [DCNT_W-1:0] cnt;

  assign rem2  = {rem, 1'b0};
  assign ext_u = {1'b0, ext};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      cnt <= '0;
      rem <= d;
      bin <= '0;
      if (d < 0) begin
        busy <= 1'b0;
      end else if (d >= ext) begin
        busy <= 1'b0;
        bin  <= BIN_W'(BINS - 1);
      end else begin
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (rem2 >= ext_u) begin
        rem <= EXT_W'(rem2 - ext_u);
        bin <= {bin[BIN_W-2:0], 1'b1};
      end else begin
        rem <= rem2[EXT_W-1:0];
        bin <= {bin[BIN_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(BIN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
